[rtl/jvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick velocity shaper package
// Field widths, register reset values, register indexes and the structs that
// travel between the top level and the per-axis shaping lanes.
// ----------------------------------------------------------------------------
package jvs_pkg;

  localparam int RAW_W     = 12;   // converter sample width
  localparam int ABS_W     = 12;   // magnitude of the deflection, 0..2048
  localparam int CFG_W     = 11;   // widest configuration register
  localparam int SPEED_W   = 7;    // speed values, 0..127
  localparam int VEL_W     = 8;    // signed velocity
  localparam int IDX_W     = 3;    // register index width

  localparam int CENTER           = 2048;
  localparam int SPEED_MAX        = 127;
  localparam int BOOST_FACTOR_DEF = 2;

  localparam logic [CFG_W-1:0]   DEADZONE_RST    = 11'd100;
  localparam logic [CFG_W-1:0]   BEND_LOW_RST    = 11'd512;
  localparam logic [CFG_W-1:0]   BEND_MID_RST    = 11'd1536;
  localparam logic [SPEED_W-1:0] SPEED_LOW_RST   = 7'd2;
  localparam logic [SPEED_W-1:0] SPEED_MID_RST   = 7'd4;
  localparam logic [SPEED_W-1:0] SPEED_HIGH_RST  = 7'd8;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 7'd8;
  localparam logic [SPEED_W-1:0] ACCEL_STEP_RST  = 7'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_DEADZONE    = 3'd0,
    REG_BEND_LOW    = 3'd1,
    REG_BEND_MID    = 3'd2,
    REG_SPEED_LOW   = 3'd3,
    REG_SPEED_MID   = 3'd4,
    REG_SPEED_HIGH  = 3'd5,
    REG_SPEED_LIMIT = 3'd6,
    REG_ACCEL_STEP  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]   deadzone;
    logic [CFG_W-1:0]   bend_low;
    logic [CFG_W-1:0]   bend_mid;
    logic [SPEED_W-1:0] speed_low;
    logic [SPEED_W-1:0] speed_mid;
    logic [SPEED_W-1:0] speed_high;
    logic [SPEED_W-1:0] speed_limit;
    logic [SPEED_W-1:0] accel_step;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             boost;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity_x;
    logic signed [VEL_W-1:0] velocity_y;
  } out_item_t;

  // Handshake from the top level into a lane.
  typedef struct packed {
    logic start;   // load a new sample
    logic ack;     // result taken, lane may return to idle
  } lane_ctrl_t;

  // What a lane reports back.
  typedef struct packed {
    logic                    done;
    logic signed [VEL_W-1:0] vel;
  } axis_res_t;

endpackage

[rtl/jvs_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis shaping lane
// Deadzone, piecewise-linear speed curve with a bit-serial multiply and
// restoring divide, limit, boost and slew toward the target velocity.
// ----------------------------------------------------------------------------
module jvs_axis #(
  parameter int BOOST_FACTOR = jvs_pkg::BOOST_FACTOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  jvs_pkg::lane_ctrl_t         ctrl,
  input  logic [jvs_pkg::RAW_W-1:0]   raw,
  input  logic                        boost,
  input  jvs_pkg::cfg_t               cfg,
  output jvs_pkg::axis_res_t          res
);
  import jvs_pkg::*;

  localparam int ProdW  = ABS_W + SPEED_W;
  localparam int BoostW = $clog2(SPEED_MAX * BOOST_FACTOR + 1);
  localparam int CntW   = $clog2(SPEED_W);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ABS  = 8'b0000_0010,
    S_SEG  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_TGT  = 8'b0010_0000,
    S_SLEW = 8'b0100_0000,
    S_HOLD = 8'b1000_0000
  } axis_state_t;

  axis_state_t state;

  logic [RAW_W-1:0]         raw_q;
  logic                     boost_q;
  logic                     neg_q;
  logic [ABS_W-1:0]         a_q;
  logic [SPEED_W-1:0]       m_q;
  logic [SPEED_W-1:0]       base_q;
  logic                     sub_q;
  logic [ProdW-1:0]         mcand_q;
  logic [ProdW-1:0]         prod_q;
  logic [ProdW-1:0]         dsr_q;
  logic [SPEED_W-1:0]       quo_q;
  logic [CntW-1:0]          cnt;
  logic signed [VEL_W-1:0]  target_q;
  logic signed [VEL_W-1:0]  cur;

  // Deadzone and magnitude.
  logic signed [RAW_W:0] delta;
  logic signed [RAW_W:0] dz_s;
  logic                  in_band;
  logic                  neg_next;
  logic [ABS_W-1:0]      a_next;

  always_comb begin
    delta    = $signed({1'b0, raw_q}) - $signed((RAW_W + 1)'(CENTER));
    dz_s     = $signed({2'b00, cfg.deadzone});
    in_band  = (delta > -dz_s) && (delta < dz_s);
    neg_next = !in_band && !delta[RAW_W] && (delta != '0);
    if (in_band) begin
      a_next = '0;
    end else if (delta[RAW_W]) begin
      a_next = ABS_W'(-delta);
    end else begin
      a_next = ABS_W'(delta);
    end
  end

  // Segment selection: offset into the segment, speed rise, span.
  logic                  lt_low;
  logic                  lt_mid;
  logic [ABS_W-1:0]      n_next;
  logic [SPEED_W-1:0]    m_next;
  logic [SPEED_W-1:0]    base_next;
  logic                  sub_next;
  logic [ABS_W-1:0]      den_next;

  always_comb begin
    lt_low = a_q < {1'b0, cfg.bend_low};
    lt_mid = a_q < {1'b0, cfg.bend_mid};
    priority if (lt_low) begin
      n_next    = a_q;
      m_next    = cfg.speed_low;
      base_next = '0;
      sub_next  = 1'b0;
      den_next  = {1'b0, cfg.bend_low};
    end else if (lt_mid) begin
      n_next    = a_q - {1'b0, cfg.bend_low};
      sub_next  = cfg.speed_mid < cfg.speed_low;
      m_next    = sub_next ? cfg.speed_low - cfg.speed_mid
                           : cfg.speed_mid - cfg.speed_low;
      base_next = cfg.speed_low;
      den_next  = {1'b0, cfg.bend_mid} - {1'b0, cfg.bend_low};
    end else begin
      n_next    = a_q - {1'b0, cfg.bend_mid};
      sub_next  = cfg.speed_high < cfg.speed_mid;
      m_next    = sub_next ? cfg.speed_mid - cfg.speed_high
                           : cfg.speed_high - cfg.speed_mid;
      base_next = cfg.speed_mid;
      den_next  = ABS_W'(CENTER) - {1'b0, cfg.bend_mid};
    end
  end

  // The quotient never exceeds the speed rise, so SPEED_W quotient bits do.
  logic             div_fit;
  logic [ProdW-1:0] rem_next;

  always_comb begin
    div_fit  = prod_q >= dsr_q;
    rem_next = div_fit ? prod_q - dsr_q : prod_q;
  end

  // Curve value, limit, boost and sign.
  logic [SPEED_W-1:0]      v;
  logic [SPEED_W-1:0]      vm;
  logic [BoostW-1:0]       boosted;
  logic [SPEED_W-1:0]      mag;
  logic signed [VEL_W-1:0] target_next;

  always_comb begin
    v       = sub_q ? base_q - quo_q : base_q + quo_q;
    vm      = (v > cfg.speed_limit) ? cfg.speed_limit : v;
    boosted = BoostW'(vm) * BoostW'(BOOST_FACTOR);
    if (!boost_q) begin
      mag = vm;
    end else if (boosted > BoostW'(SPEED_MAX)) begin
      mag = SPEED_W'(SPEED_MAX);
    end else begin
      mag = boosted[SPEED_W-1:0];
    end
    target_next = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Slew toward the target without overshoot.
  logic signed [VEL_W:0]   cur_w;
  logic signed [VEL_W:0]   tgt_w;
  logic signed [VEL_W:0]   up;
  logic signed [VEL_W:0]   dn;
  logic signed [VEL_W-1:0] cur_next;

  always_comb begin
    cur_w = {cur[VEL_W-1], cur};
    tgt_w = {target_q[VEL_W-1], target_q};
    up    = cur_w + $signed({2'b00, cfg.accel_step});
    dn    = cur_w - $signed({2'b00, cfg.accel_step});
    priority if (cur < target_q) begin
      cur_next = (up > tgt_w) ? target_q : up[VEL_W-1:0];
    end else if (cur > target_q) begin
      cur_next = (dn < tgt_w) ? target_q : dn[VEL_W-1:0];
    end else begin
      cur_next = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          state <= S_SEG;
        end
        S_SEG: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (cnt == CntW'(SPEED_W - 1)) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt == CntW'(SPEED_W - 1)) begin
            cnt   <= '0;
            state <= S_TGT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TGT: begin
          state <= S_SLEW;
        end
        S_SLEW: begin
          cur   <= cur_next;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (ctrl.ack) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && ctrl.start) begin
      raw_q   <= raw;
      boost_q <= boost;
    end
    if (state == S_ABS) begin
      a_q   <= a_next;
      neg_q <= neg_next;
    end
    if (state == S_SEG) begin
      mcand_q <= ProdW'(n_next);
      m_q     <= m_next;
      base_q  <= base_next;
      sub_q   <= sub_next;
      prod_q  <= '0;
      dsr_q   <= ProdW'(den_next) << (SPEED_W - 1);
      quo_q   <= '0;
    end
    if (state == S_MUL) begin
      if (m_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q <= mcand_q << 1;
      m_q     <= m_q >> 1;
    end
    if (state == S_DIV) begin
      prod_q <= rem_next;
      quo_q  <= {quo_q[SPEED_W-2:0], div_fit};
      dsr_q  <= dsr_q >> 1;
    end
    if (state == S_TGT) begin
      target_q <= target_next;
    end
  end

  assign res.done = (state == S_HOLD);
  assign res.vel  = cur;

endmodule

[rtl/joystick_velocity_shaper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick velocity shaper
// Turns two joystick samples and a boost button into two slewed velocities.
// ----------------------------------------------------------------------------
// Usage:
//   An input item (raw_x, raw_y, boost) is taken on in_valid/in_ready. Each
//   axis runs in its own lane: deadzone and inversion, a three-segment speed
//   curve, a speed limit, optional boost with saturation to +-127, and a slew
//   of the kept velocity toward that target by at most accel_step.
//   The output item carries the two updated velocities on out_valid/out_ready.
//   The lanes take one item at a time, so a new item is accepted only once
//   the previous result has moved into the output register. Each lane has
//   one shift-add multiplier and one restoring divider, which work one bit
//   per cycle.
//   An output register holds the finished item, so the next input item can be
//   accepted while the receiver stalls; that next result then waits in its
//   lane until the output register is free.
//   Reset returns control and configuration registers to their defaults and
//   both kept velocities to zero. The user writes configuration via cfg_we,
//   cfg_index, cfg_data only when idle (unenforced); the next item uses it.
// ----------------------------------------------------------------------------
module joystick_velocity_shaper #(
  parameter int BOOST_FACTOR = jvs_pkg::BOOST_FACTOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  jvs_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output jvs_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [jvs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [jvs_pkg::CFG_W-1:0]   cfg_data
);
  import jvs_pkg::*;

  cfg_t       cfg;
  logic       busy;
  lane_ctrl_t ctrl;
  axis_res_t  res_x;
  axis_res_t  res_y;

  // One item is in the lanes at a time; busy covers it from acceptance
  // until its result moves into the output register.
  assign in_ready   = !busy;
  assign ctrl.start = in_valid && in_ready;
  // Both lanes run in lockstep; the result moves out once the output
  // register is empty or being emptied in this cycle.
  assign ctrl.ack   = res_x.done && res_y.done && (!out_valid || out_ready);

  jvs_axis #(
    .BOOST_FACTOR (BOOST_FACTOR)
  ) u_axis_x (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .raw   (in_item.raw_x),
    .boost (in_item.boost),
    .cfg   (cfg),
    .res   (res_x)
  );

  jvs_axis #(
    .BOOST_FACTOR (BOOST_FACTOR)
  ) u_axis_y (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .raw   (in_item.raw_y),
    .boost (in_item.boost),
    .cfg   (cfg),
    .res   (res_y)
  );

  // Configuration registers and handshake control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone    <= DEADZONE_RST;
      cfg.bend_low    <= BEND_LOW_RST;
      cfg.bend_mid    <= BEND_MID_RST;
      cfg.speed_low   <= SPEED_LOW_RST;
      cfg.speed_mid   <= SPEED_MID_RST;
      cfg.speed_high  <= SPEED_HIGH_RST;
      cfg.speed_limit <= SPEED_LIMIT_RST;
      cfg.accel_step  <= ACCEL_STEP_RST;
      busy            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DEADZONE:    cfg.deadzone    <= cfg_data;
          REG_BEND_LOW:    cfg.bend_low    <= cfg_data;
          REG_BEND_MID:    cfg.bend_mid    <= cfg_data;
          REG_SPEED_LOW:   cfg.speed_low   <= cfg_data[SPEED_W-1:0];
          REG_SPEED_MID:   cfg.speed_mid   <= cfg_data[SPEED_W-1:0];
          REG_SPEED_HIGH:  cfg.speed_high  <= cfg_data[SPEED_W-1:0];
          REG_SPEED_LIMIT: cfg.speed_limit <= cfg_data[SPEED_W-1:0];
          REG_ACCEL_STEP:  cfg.accel_step  <= cfg_data[SPEED_W-1:0];
        endcase
      end
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (ctrl.ack) begin
        busy <= 1'b0;
      end
      if (ctrl.ack) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (ctrl.ack) begin
      out_item.velocity_x <= res_x.vel;
      out_item.velocity_y <= res_y.vel;
    end
  end

endmodule

[rtl/jvs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick velocity shaper checker
// Port-level properties of the shaper, attached to the top level by bind.
// ----------------------------------------------------------------------------
module jvs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input jvs_pkg::in_item_t           in_item,
  input logic                        out_valid,
  input logic                        out_ready,
  input jvs_pkg::out_item_t          out_item
);
  import jvs_pkg::*;

  // Reset empties the block: no result pending, ready for an item.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("shaper not idle after reset");

  // Only one item is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // An offered item waits unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_item)))
    else $error("offered item changed while waiting");

  // Velocities saturate at +-127 and never show the most negative code.
  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.velocity_x != -8'sd128) &&
                   (out_item.velocity_y != -8'sd128)))
    else $error("velocity out of range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind joystick_velocity_shaper jvs_checker u_jvs_checker (.*);

[bench/tb_joystick_velocity_shaper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick velocity shaper testbench
// Drives joystick samples through the valid/ready input and checks every
// output item against a cycle-free model of the deadzone, the speed curve,
// boost saturation and the velocity slew. The run steps through several
// register settings and idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
module tb_joystick_velocity_shaper;
  import jvs_pkg::*;

  localparam int BOOST          = BOOST_FACTOR_DEF;
  localparam int SETTLE_CYCLES  = 30;    // a little more than the latency
  localparam int HOLDOFF_CYCLES = 400;   // long output stall, many item times
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 44;    // per half phase

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  in_item_t       in_item   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_item_t      out_item;
  logic           cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Shadow of the register file and of the kept velocities.
  cfg_t                    shadow_cfg;
  logic signed [VEL_W-1:0] kept_vx;
  logic signed [VEL_W-1:0] kept_vy;

  in_item_t  pending_items[$];
  out_item_t predicted_vel[$];
  out_item_t want;

  int errors        = 0;
  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int rx_holdoff    = 0;
  bit holdoff_req   = 1'b0;

  always #5 clk = ~clk;

  joystick_velocity_shaper #(
    .BOOST_FACTOR(BOOST)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Target speed of one axis. The sample is centered, pushed to zero inside
  // the deadzone and inverted; its magnitude then walks the three-segment
  // curve. Division truncates toward zero in both languages, which matters
  // when a segment slopes downward.
  function automatic int axis_target(logic [RAW_W-1:0] raw, logic boost);
    int delta, dz, d, a, v, bl, bm, sl, sm, sh, lim;
    dz  = int'(shadow_cfg.deadzone);
    bl  = int'(shadow_cfg.bend_low);
    bm  = int'(shadow_cfg.bend_mid);
    sl  = int'(shadow_cfg.speed_low);
    sm  = int'(shadow_cfg.speed_mid);
    sh  = int'(shadow_cfg.speed_high);
    lim = int'(shadow_cfg.speed_limit);
    delta = int'(raw) - CENTER;
    if (delta > -dz && delta < dz) delta = 0;
    d = -delta;
    a = (d < 0) ? -d : d;
    // A zero first breakpoint skips the first segment, and breakpoints out
    // of order skip the middle one.
    if (a < bl) begin
      v = (a * sl) / bl;
    end else if (a < bm) begin
      v = sl + ((a - bl) * (sm - sl)) / (bm - bl);
    end else begin
      v = sm + ((a - bm) * (sh - sm)) / (CENTER - bm);
    end
    if (v > lim) v = lim;
    if (d < 0) v = -v;
    // Boost saturates instead of wrapping.
    if (boost) begin
      v = v * BOOST;
      if (v > SPEED_MAX) v = SPEED_MAX;
      if (v < -SPEED_MAX) v = -SPEED_MAX;
    end
    return v;
  endfunction

  // Move a kept velocity toward its target without overshoot. A zero step
  // leaves it where it is.
  function automatic logic signed [VEL_W-1:0] slew_toward(logic signed [VEL_W-1:0] cur,
                                                          int target);
    int c, step;
    c    = int'(cur);
    step = int'(shadow_cfg.accel_step);
    if (c < target) begin
      c = c + step;
      if (c > target) c = target;
    end else if (c > target) begin
      c = c - step;
      if (c < target) c = target;
    end
    return c[VEL_W-1:0];
  endfunction

  task automatic advance_velocity(in_item_t s);
    out_item_t r;
    kept_vx = slew_toward(kept_vx, axis_target(s.raw_x, s.boost));
    kept_vy = slew_toward(kept_vy, axis_target(s.raw_y, s.boost));
    r.velocity_x = kept_vx;
    r.velocity_y = kept_vy;
    predicted_vel.push_back(r);
  endtask

  // Sender. An accepted item is predicted on the edge that takes it; a new
  // item is offered only when the channel is free or has just been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_velocity(in_item);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. A long hold-off, once requested, is counted down
  // here so that the block fills up while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_vel.size() == 0) begin
          $display("%0t: unexpected output item vx=%0d vy=%0d", $time,
                   out_item.velocity_x, out_item.velocity_y);
          errors++;
        end else begin
          want = predicted_vel.pop_front();
          if (out_item.velocity_x !== want.velocity_x) begin
            $display("%0t: velocity_x mismatch, expected %0d, got %0d", $time,
                     want.velocity_x, out_item.velocity_x);
            errors++;
          end
          if (out_item.velocity_y !== want.velocity_y) begin
            $display("%0t: velocity_y mismatch, expected %0d, got %0d", $time,
                     want.velocity_y, out_item.velocity_y);
            errors++;
          end
        end
      end
      if (holdoff_req) begin
        rx_holdoff  = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (rx_holdoff > 0) begin
        out_ready <= 1'b0;
        rx_holdoff--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Wait until every queued item has gone in and every result has come out,
  // then let the lanes settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || predicted_vel.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: data is masked to the register width in the shadow, as
  // the block keeps only the low bits of a narrow register.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DEADZONE:    shadow_cfg.deadzone    = data;
      REG_BEND_LOW:    shadow_cfg.bend_low    = data;
      REG_BEND_MID:    shadow_cfg.bend_mid    = data;
      REG_SPEED_LOW:   shadow_cfg.speed_low   = data[SPEED_W-1:0];
      REG_SPEED_MID:   shadow_cfg.speed_mid   = data[SPEED_W-1:0];
      REG_SPEED_HIGH:  shadow_cfg.speed_high  = data[SPEED_W-1:0];
      REG_SPEED_LIMIT: shadow_cfg.speed_limit = data[SPEED_W-1:0];
      REG_ACCEL_STEP:  shadow_cfg.accel_step  = data[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_sample(int rx, int ry, logic boost);
    in_item_t s;
    s.raw_x = rx[RAW_W-1:0];
    s.raw_y = ry[RAW_W-1:0];
    s.boost = boost;
    pending_items.push_back(s);
  endtask

  // Samples are drawn mostly from the whole range, with a share aimed at the
  // ends of travel, the center, the deadzone edges and the curve breakpoints.
  function automatic logic [RAW_W-1:0] pick_raw();
    int v, side, pivot;
    side = $urandom_range(1) ? 1 : -1;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? 0 : 4095;
      1: v = CENTER + $urandom_range(0, 6) - 3;
      2: v = CENTER + side * int'(shadow_cfg.deadzone) + $urandom_range(0, 2) - 1;
      3: begin
        pivot = $urandom_range(1) ? int'(shadow_cfg.bend_low) : int'(shadow_cfg.bend_mid);
        v = CENTER + side * pivot + $urandom_range(0, 2) - 1;
      end
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  // Random items, often held for several frames so that the slew reaches
  // and settles on its target.
  task automatic queue_random(int count);
    int n, reps;
    in_item_t s;
    n = 0;
    while (n < count) begin
      s.raw_x = pick_raw();
      s.raw_y = pick_raw();
      s.boost = 1'($urandom_range(1));
      reps = ($urandom_range(3) == 0) ? $urandom_range(2, 10) : 1;
      repeat (reps) begin
        pending_items.push_back(s);
        n++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] setting[8];
    shadow_cfg = '{deadzone:    DEADZONE_RST,    bend_low:   BEND_LOW_RST,
                   bend_mid:    BEND_MID_RST,    speed_low:  SPEED_LOW_RST,
                   speed_mid:   SPEED_MID_RST,   speed_high: SPEED_HIGH_RST,
                   speed_limit: SPEED_LIMIT_RST, accel_step: ACCEL_STEP_RST};
    kept_vx = '0;
    kept_vy = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings: ends of travel, center,
    // both sides of each deadzone edge, the breakpoints, and boost runs that
    // drive the velocities toward their extremes and back.
    @(negedge clk);
    queue_sample(0, 0, 1'b0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(2048, 2048, 1'b0);
    queue_sample(1948, 2148, 1'b0);
    queue_sample(1949, 2147, 1'b0);
    queue_sample(1536, 2560, 1'b0);
    queue_sample(1537, 2559, 1'b0);
    queue_sample(512, 3584, 1'b0);
    queue_sample(513, 3583, 1'b1);
    repeat (8) queue_sample(0, 4095, 1'b1);
    repeat (8) queue_sample(4095, 0, 1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      for (int r = 0; r < 8; r++) setting[r] = CFG_W'($urandom_range(0, 2047));
      case (p)
        0: setting = '{11'd0, 11'd1, 11'd2, 11'd0, 11'd127, 11'd0, 11'd127, 11'd1};
        1: setting = '{11'd2047, 11'd2045, 11'd2047, 11'd127, 11'd127, 11'd127,
                       11'd127, 11'd127};
        // First breakpoint at zero.
        2: setting = '{11'd20, 11'd0, 11'd1024, 11'd10, 11'd40, 11'd90, 11'd100, 11'd5};
        // Breakpoints out of order.
        3: setting = '{11'd60, 11'd1500, 11'd300, 11'd30, 11'd70, 11'd20, 11'd50, 11'd3};
        // Boost products well past the saturation point.
        4: setting = '{11'd50, 11'd400, 11'd1200, 11'd60, 11'd100, 11'd127, 11'd127,
                       11'd127};
        // Upper bits set on the step register leave a zero step, so the
        // velocities left by the previous phase must hold.
        5: setting[REG_ACCEL_STEP] = 11'h080;
        default: ;
      endcase
      for (int r = 0; r < 8; r++) write_reg(reg_idx_t'(r), setting[r]);
      @(posedge clk);
      cfg_we <= 1'b0;

      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin send_idle_pct = 23; rx_stall_pct = 23; end
      endcase

      @(negedge clk);
      if (p == 0) holdoff_req = 1'b1;
      queue_random(PHASE_ITEMS);
      // The sender pauses here until every result is back.
      wait_drained();
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
